@@ sv/sector_circle_proximity_test_core_macros.svh @@
// Assertion helpers, used only by scpt_fifo. All checks run on aclk and are
// switched off while aresetn is low.
`ifndef SECTOR_CIRCLE_PROXIMITY_TEST_CORE_MACROS_SVH
`define SECTOR_CIRCLE_PROXIMITY_TEST_CORE_MACROS_SVH

// Same-cycle implication.
`define SCPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SCPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/scpt_pkg.sv @@
`default_nettype none
package scpt_pkg;

    localparam int COORD_BITS_DEF      = 10;
    localparam int ANGLE_FRAC_BITS_DEF = 4;
    localparam int FIFO_DEPTH_DEF      = 4;

    localparam int CORDIC_STEPS = 16;
    localparam int PRESCALE     = 20;

    localparam logic [10:0] RANGE_RESET = 11'd100;
    localparam logic [8:0]  FOV_RESET   = 9'd100;
    localparam logic [14:0] DIST_MAX    = 15'd32767;

    // Register selects on paddr[2].
    localparam logic REG_SENSING_RANGE = 1'b0;
    localparam logic REG_FIELD_OF_VIEW = 1'b1;

    // atan(2^-i) in degrees scaled by 65536.
    localparam logic [22:0] ATAN_Q16 [CORDIC_STEPS] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234379,  23'd117304,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115
    };

endpackage
`default_nettype wire

@@ sv/scpt_front.sv @@
`default_nettype none
module scpt_front #(
    parameter int COORD_BITS = scpt_pkg::COORD_BITS_DEF,
    parameter int QW         = 4 * COORD_BITS + 25
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [9:0]    sensor_x,
    input  wire logic [9:0]    sensor_y,
    input  wire logic [9:0]    target_x,
    input  wire logic [9:0]    target_y,
    input  wire logic [7:0]    target_radius,
    input  wire logic [13:0]   heading,
    input  wire logic [10:0]   sensing_range,
    input  wire logic          q_full,
    output logic               q_push,
    output logic [QW-1:0]      q_data
);
    localparam int CB   = COORD_BITS;
    localparam int D2_W = 2 * CB + 1;

    logic [CB-1:0] sx, sy, tx, ty;
    logic          v1_reg, v2_reg;
    logic [CB-1:0] adx1_reg, ady1_reg, adx2_reg, ady2_reg;
    logic          negx1_reg, negx2_reg;
    logic [7:0]    r1_reg, r2_reg;
    logic [13:0]   hd1_reg, hd2_reg;
    logic [11:0]   lim_reg;
    logic [D2_W-1:0] d2_reg;
    logic [23:0]   limsq_reg;
    logic [2*CB-1:0] sqx, sqy;
    logic          adv1, adv2, miss;

    assign sx = CB'(sensor_x);
    assign sy = CB'(sensor_y);
    assign tx = CB'(target_x);
    assign ty = CB'(target_y);

    assign adv2     = !v2_reg || !q_full;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign sqx = adx1_reg * adx1_reg;
    assign sqy = ady1_reg * ady1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1) begin
            adx1_reg  <= (tx >= sx) ? tx - sx : sx - tx;
            ady1_reg  <= (ty >= sy) ? ty - sy : sy - ty;
            negx1_reg <= tx < sx;
            r1_reg    <= target_radius;
            hd1_reg   <= heading;
            lim_reg   <= {1'b0, sensing_range} + {4'h0, target_radius};
        end
        if (adv2) begin
            adx2_reg  <= adx1_reg;
            ady2_reg  <= ady1_reg;
            negx2_reg <= negx1_reg;
            r2_reg    <= r1_reg;
            hd2_reg   <= hd1_reg;
            d2_reg    <= {1'b0, sqx} + {1'b0, sqy};
            limsq_reg <= lim_reg * lim_reg;
        end
    end

    assign miss   = d2_reg > limsq_reg;
    assign q_push = v2_reg && !q_full;
    assign q_data = {miss, d2_reg, hd2_reg, r2_reg, negx2_reg, ady2_reg, adx2_reg};

endmodule
`default_nettype wire

@@ sv/scpt_fifo.sv @@
`default_nettype none
module scpt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = scpt_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push_i,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop_i,
    output logic              not_empty,
    output logic [W-1:0]      dout
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full      = count_reg == (AW + 1)'(DEPTH);
    assign not_empty = count_reg != '0;
    assign dout      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop_i)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push_i && !pop_i)
                count_reg <= count_reg + 1'b1;
            else if (pop_i && !push_i)
                count_reg <= count_reg - 1'b1;
        end
        if (push_i)
            mem_reg[wr_ptr_reg] <= din;
    end

`include "sector_circle_proximity_test_core_macros.svh"
    `SCPT_ASSERT_IMPL(a_no_overflow, push_i, !full)
    `SCPT_ASSERT_IMPL(a_no_underflow, pop_i, not_empty)
    `SCPT_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_reg == $past(count_reg) + 1'b1)

endmodule
`default_nettype wire

@@ sv/scpt_back.sv @@
`default_nettype none
module scpt_back #(
    parameter int COORD_BITS      = scpt_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = scpt_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int QW              = 4 * COORD_BITS + 25
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_pop,
    input  wire logic [QW-1:0] in_data,
    input  wire logic [8:0]    field_of_view,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               detected,
    output logic [14:0]        distance
);
    localparam int CB    = COORD_BITS;
    localparam int AF    = ANGLE_FRAC_BITS;
    localparam int D2_W  = 2 * CB + 1;
    localparam int SQ_N  = (D2_W + 17) / 2;
    localparam int RAD_W = 2 * SQ_N;
    localparam int RW    = SQ_N + 2;
    localparam int NCS   = scpt_pkg::CORDIC_STEPS;
    localparam int PS    = scpt_pkg::PRESCALE;
    localparam int CIN_W = (SQ_N > 16) ? SQ_N : 16;
    localparam int CW    = CIN_W + PS + 3;
    localparam int ZW    = 25;
    localparam int AGW   = 7 + AF;
    localparam int CMP_W = AF + 16;
    localparam int SB_W  = 25;
    localparam int NST   = SQ_N + NCS;
    localparam logic signed [ZW-1:0] Z90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] ZRND = ZW'(2 ** (15 - AF));

    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input int s);
        shr_tz = v[CW-1] ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic logic [AGW-1:0] quant(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] c;
        c = z;
        if (z < 0)
            c = '0;
        else if (z > Z90)
            c = Z90;
        quant = AGW'((c + ZRND) >>> (16 - AF));
    endfunction

    logic adv;
    logic [NST-1:0] vld_reg;
    logic           out_v_reg, det_reg;
    logic [14:0]    dist_reg;

    // Entry unpack: sideband is {miss, zero, neg_x, heading, radius}.
    logic [CB-1:0]   e_adx, e_ady;
    logic [D2_W-1:0] e_d2;
    logic [SB_W-1:0] e_sb;

    assign e_adx = in_data[CB-1:0];
    assign e_ady = in_data[2*CB-1:CB];
    assign e_d2  = in_data[2*CB+23+D2_W-1:2*CB+23];
    assign e_sb  = {in_data[QW-1], e_d2 == '0, in_data[2*CB], in_data[2*CB+22:2*CB+1]};

    assign adv    = !out_v_reg || out_ready;
    assign in_pop = adv && in_valid;

    // Square root, one result bit per stage.
    logic [RW-1:0]    sq_rem_reg  [SQ_N];
    logic [SQ_N-1:0]  sq_root_reg [SQ_N];
    logic [RAD_W-1:0] sq_rad_reg  [SQ_N];
    logic [CB-1:0]    sq_adx_reg  [SQ_N];
    logic [CB-1:0]    sq_ady_reg  [SQ_N];
    logic [SB_W-1:0]  sq_sb_reg   [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        logic [RW-1:0]    rem_in, rem_sh, trial;
        logic [SQ_N-1:0]  root_in;
        logic [RAD_W-1:0] rad_in;
        logic [CB-1:0]    ax_in, ay_in;
        logic [SB_W-1:0]  sb_in;
        logic             take;
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'({e_d2, 16'h0000});
            assign ax_in   = e_adx;
            assign ay_in   = e_ady;
            assign sb_in   = e_sb;
        end else begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign rad_in  = sq_rad_reg[k-1];
            assign ax_in   = sq_adx_reg[k-1];
            assign ay_in   = sq_ady_reg[k-1];
            assign sb_in   = sq_sb_reg[k-1];
        end
        assign rem_sh = {rem_in[RW-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = rem_sh >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[k]  <= take ? rem_sh - trial : rem_sh;
                sq_root_reg[k] <= {root_in[SQ_N-2:0], take};
                sq_rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                sq_adx_reg[k]  <= ax_in;
                sq_ady_reg[k]  <= ay_in;
                sq_sb_reg[k]   <= sb_in;
            end
        end
    end

    // Two vectoring CORDICs side by side: bearing and half-width.
    logic signed [CW-1:0] cr_bx_reg [NCS];
    logic signed [CW-1:0] cr_by_reg [NCS];
    logic signed [ZW-1:0] cr_bz_reg [NCS];
    logic signed [CW-1:0] cr_hx_reg [NCS];
    logic signed [CW-1:0] cr_hy_reg [NCS];
    logic signed [ZW-1:0] cr_hz_reg [NCS];
    logic [SQ_N-1:0]      cr_root_reg [NCS];
    logic [SB_W-1:0]      cr_sb_reg [NCS];

    for (genvar j = 0; j < NCS; j++) begin : g_cr
        localparam logic signed [ZW-1:0] ATAN_C = ZW'(scpt_pkg::ATAN_Q16[j]);
        logic signed [CW-1:0] bx, by, hx, hy, bxs, bys, hxs, hys;
        logic signed [ZW-1:0] bz, hz;
        logic [SQ_N-1:0]      root_in;
        logic [SB_W-1:0]      sb_in;
        if (j == 0) begin : g_first
            logic [SQ_N-1:0] rt;
            logic [7:0]      rad;
            assign rt      = sq_root_reg[SQ_N-1];
            assign rad     = sq_sb_reg[SQ_N-1][7:0];
            assign bx      = CW'({sq_adx_reg[SQ_N-1], 20'h00000});
            assign by      = CW'({sq_ady_reg[SQ_N-1], 20'h00000});
            assign hx      = CW'({rt, 20'h00000});
            assign hy      = CW'({rad, 28'h0000000});
            assign bz      = '0;
            assign hz      = '0;
            assign root_in = rt;
            assign sb_in   = sq_sb_reg[SQ_N-1];
        end else begin : g_rest
            assign bx      = cr_bx_reg[j-1];
            assign by      = cr_by_reg[j-1];
            assign bz      = cr_bz_reg[j-1];
            assign hx      = cr_hx_reg[j-1];
            assign hy      = cr_hy_reg[j-1];
            assign hz      = cr_hz_reg[j-1];
            assign root_in = cr_root_reg[j-1];
            assign sb_in   = cr_sb_reg[j-1];
        end
        assign bxs = shr_tz(bx, j);
        assign bys = shr_tz(by, j);
        assign hxs = shr_tz(hx, j);
        assign hys = shr_tz(hy, j);
        always_ff @(posedge aclk) begin
            if (adv) begin
                cr_bx_reg[j]   <= by[CW-1] ? bx - bys : bx + bys;
                cr_by_reg[j]   <= by[CW-1] ? by + bxs : by - bxs;
                cr_bz_reg[j]   <= by[CW-1] ? bz - ATAN_C : bz + ATAN_C;
                cr_hx_reg[j]   <= hy[CW-1] ? hx - hys : hx + hys;
                cr_hy_reg[j]   <= hy[CW-1] ? hy + hxs : hy - hxs;
                cr_hz_reg[j]   <= hy[CW-1] ? hz - ATAN_C : hz + ATAN_C;
                cr_root_reg[j] <= root_in;
                cr_sb_reg[j]   <= sb_in;
            end
        end
    end

    // Final stage: quantize angles, place arcs, test overlap, saturate distance.
    logic [SB_W-1:0]        f_sb;
    logic                   f_miss, f_zero, f_negx;
    logic signed [13:0]     f_hd;
    logic [AGW-1:0]         b_q, h_q;
    logic signed [CMP_W-1:0] bear, halfw, s_half, hd_s, s_lo, s_hi, t_lo, t_hi;
    logic [SQ_N-5:0]        d_sh;
    logic [14:0]            d_sat;
    logic                   hit;

    assign f_sb   = cr_sb_reg[NCS-1];
    assign f_miss = f_sb[24];
    assign f_zero = f_sb[23];
    assign f_negx = f_sb[22];
    assign f_hd   = signed'(f_sb[21:8]);

    assign b_q    = f_zero ? '0 : quant(cr_bz_reg[NCS-1]);
    assign h_q    = quant(cr_hz_reg[NCS-1]);
    assign bear   = f_negx ? (CMP_W'(180) << AF) - CMP_W'(b_q) : CMP_W'(b_q);
    assign halfw  = f_zero ? (CMP_W'(90) << AF) : CMP_W'(h_q);
    assign s_half = CMP_W'(field_of_view[8:1]) << AF;
    assign hd_s   = CMP_W'(f_hd);
    assign s_lo   = hd_s - s_half;
    assign s_hi   = hd_s + s_half;
    assign t_lo   = bear - halfw;
    assign t_hi   = bear + halfw;
    assign hit    = !f_miss && (t_lo <= s_hi) && (t_hi >= s_lo);

    assign d_sh   = cr_root_reg[NCS-1][SQ_N-1:4];
    assign d_sat  = (d_sh > scpt_pkg::DIST_MAX) ? scpt_pkg::DIST_MAX : 15'(d_sh);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            vld_reg   <= {vld_reg[NST-2:0], in_valid};
            out_v_reg <= vld_reg[NST-1];
        end
        if (adv) begin
            det_reg  <= hit;
            dist_reg <= hit ? d_sat : '0;
        end
    end

    assign out_valid = out_v_reg;
    assign detected  = det_reg;
    assign distance  = dist_reg;

endmodule
`default_nettype wire

@@ sv/sector_circle_proximity_test_core.sv @@
// Path: front registers, result queue, unrolled root and CORDIC stages, output register.
// Throughput: one transaction per cycle unless m_tready stalls; set by the unrolled stages.
// Reset: aresetn is synchronous and active low; it empties all stages and the queue
// and loads sensing_range and field_of_view with 100.
`default_nettype none
module sector_circle_proximity_test_core #(
    parameter int COORD_BITS      = scpt_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = scpt_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int FIFO_DEPTH      = scpt_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Query input.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: sensor_x[10], sensor_y[10], target_x[10], target_y[10],
    // target_radius[8], heading[14], zero pad[2].
    input  wire logic [63:0] s_tdata,
    // Result output.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: detected[1], distance[15].
    output logic [15:0]      m_tdata,
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int QW = 4 * COORD_BITS + 25;

    // Configuration registers, read directly by the pipeline. Users must
    // change them only while no transaction is in flight; nothing enforces it.
    logic [10:0] range_reg;
    logic [8:0]  fov_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= scpt_pkg::RANGE_RESET;
            fov_reg   <= scpt_pkg::FOV_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                scpt_pkg::REG_SENSING_RANGE: range_reg <= pwdata[10:0];
                scpt_pkg::REG_FIELD_OF_VIEW: fov_reg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            scpt_pkg::REG_SENSING_RANGE: prdata = {21'h0, range_reg};
            scpt_pkg::REG_FIELD_OF_VIEW: prdata = {23'h0, fov_reg};
            default:                     prdata = '0;
        endcase
    end

    // The front end takes coordinate differences, squares them and decides
    // the range test. Its result goes into a short queue so that the front
    // keeps accepting while the back end is stalled by the result side.
    logic          q_push, q_full, q_nempty, q_pop;
    logic [QW-1:0] q_din, q_dout;

    scpt_front #(
        .COORD_BITS (COORD_BITS),
        .QW         (QW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .sensor_x      (s_tdata[9:0]),
        .sensor_y      (s_tdata[19:10]),
        .target_x      (s_tdata[29:20]),
        .target_y      (s_tdata[39:30]),
        .target_radius (s_tdata[47:40]),
        .heading       (s_tdata[61:48]),
        .sensing_range (range_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_din)
    );

    scpt_fifo #(
        .W     (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop_i     (q_pop),
        .not_empty (q_nempty),
        .dout      (q_dout)
    );

    // The back end runs the digit-by-digit square root, then the bearing and
    // half-width CORDICs in parallel, then the arc overlap test into the
    // output register. The whole back-end pipeline holds when that register
    // is full and not taken.
    logic        det;
    logic [14:0] result_dist;

    scpt_back #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .QW              (QW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_nempty),
        .in_pop        (q_pop),
        .in_data       (q_dout),
        .field_of_view (fov_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .detected      (det),
        .distance      (result_dist)
    );

    assign m_tdata = {result_dist, det};

endmodule
`default_nettype wire
